>>> src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold on every clock while out of reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Expression must never be true while out of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

>>> src/aasr_pkg.sv
`default_nettype none
package aasr_pkg;
  localparam int SAMPLE_W    = 17;
  localparam int SUM_W       = 27;
  localparam int COUNT_W     = 10;
  localparam int SPP_W       = 11;
  localparam int BYTE_W      = 8;
  localparam int MAX_SAMPLES = 1024;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = SPP_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SPP   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAMMA = 1'd1;

  // 255.99 in Q16, rounded
  localparam int SCALE_W = 24;
  localparam logic [SCALE_W-1:0] SCALE_Q16 = 24'd16776561;
  localparam int PROD_W = SUM_W + SCALE_W;

  // shared restoring unit
  localparam int RAD_W      = 44;              // radicand {0, avg, 16'b0}
  localparam int UNIT_W     = 26;
  localparam int DIV_STEPS  = SUM_W;
  localparam int SQRT_STEPS = RAD_W / 2;
  localparam int STEP_W     = 5;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 24;
endpackage
`default_nettype wire

>>> src/antialias_sample_resolve_top.sv
// Supersample resolve. Each input transaction carries one RGB sample in
// unsigned Q1.16 (65536 = 1.0); the block sums the channels and counts
// samples. A sample that does not complete a pixel is taken back to back
// with the next one. The sample that brings the count to samples_per_pixel
// (0 acts as 1, above 1024 acts as 1024) starts the resolve: every channel
// sum is divided by the effective samples_per_pixel, optionally passed
// through a gamma 2 square root, scaled by 255.99 and saturated to a byte.
// Divide and root run on one shared restoring compare/subtract unit, one
// bit per cycle, and the scale is one multiply per channel. After the final
// sample the block resolves each channel in turn (load, 27 divide steps,
// 22 root steps with gamma, multiply, store); s_axis_tready_o stays low.
// The pixel lands in an output register, so a new pixel's samples are
// taken while the last one waits on m_axis; the resolve only stalls at its
// final store if that register is still full. Configuration is written
// through cfg_we_i/cfg_index_i/cfg_data_i and must change only when idle.
`default_nettype none
`include "assert_macros.svh"
module antialias_sample_resolve_top (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // config write port
  input  wire logic                                 cfg_we_i,
  input  wire logic [aasr_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [aasr_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // sample stream
  input  wire logic                                 s_axis_tvalid_i,
  output logic                                      s_axis_tready_o,
  // tdata: sample_red[16:0], sample_green[33:17], sample_blue[50:34], zero pad
  input  wire logic [aasr_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  // pixel stream
  output logic                                      m_axis_tvalid_o,
  input  wire logic                                 m_axis_tready_i,
  // tdata: red_byte[7:0], green_byte[15:8], blue_byte[23:16]
  output logic [aasr_pkg::OUT_TDATA_W-1:0]          m_axis_tdata_o
);
  localparam int SW = aasr_pkg::SAMPLE_W;
  localparam int NW = aasr_pkg::SUM_W;
  localparam int UW = aasr_pkg::UNIT_W;
  localparam int RW = aasr_pkg::RAD_W;
  localparam int TW = aasr_pkg::STEP_W;
  localparam int BW = aasr_pkg::BYTE_W;
  localparam int PW = aasr_pkg::PROD_W;

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_SQRT  = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_STORE = 3'd5;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  logic [2:0]                        state_q, state_d;
  logic [1:0]                        ch_q, ch_d;
  logic [TW-1:0]                     step_q, step_d;
  logic [aasr_pkg::SPP_W-1:0]        spp_q;
  logic                              gamma_enable_q;
  logic [NW-1:0]                     red_sum_q, green_sum_q, blue_sum_q;
  logic [aasr_pkg::COUNT_W-1:0]      count_q;
  logic [RW-1:0]                     x_q, x_d;
  logic [UW-1:0]                     rem_q, rem_d;
  logic [NW-1:0]                     res_q, res_d;
  logic [PW-1:0]                     prod_q;
  logic [BW-1:0]                     red_byte_q, green_byte_q;
  logic [aasr_pkg::OUT_TDATA_W-1:0]  m_data_q;
  logic                              m_valid_q;

  logic [aasr_pkg::SPP_W-1:0]        n_eff;
  logic                              s_fire, finish, out_free, last_step, store_out;
  logic [NW-1:0]                     chan_sum;
  logic [UW-1:0]                     unit_a, unit_b, unit_diff;
  logic                              unit_ge;
  logic [BW-1:0]                     chan_byte;

  // effective samples per pixel
  always_comb begin
    if (spp_q == '0) begin
      n_eff = aasr_pkg::SPP_W'(1);
    end else if (spp_q > aasr_pkg::SPP_W'(aasr_pkg::MAX_SAMPLES)) begin
      n_eff = aasr_pkg::SPP_W'(aasr_pkg::MAX_SAMPLES);
    end else begin
      n_eff = spp_q;
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign finish   = ({1'b0, count_q} + aasr_pkg::SPP_W'(1)) >= n_eff;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign last_step = (step_q == '0);
  assign store_out = (state_q == S_STORE) && (ch_q == CH_BLUE) && out_free;

  always_comb begin
    case (ch_q)
      CH_RED:   chan_sum = red_sum_q;
      CH_GREEN: chan_sum = green_sum_q;
      default:  chan_sum = blue_sum_q;
    endcase
  end

  // shared restoring unit: divide shifts in one dividend bit against n,
  // root shifts in two radicand bits against {root, 01}
  always_comb begin
    if (state_q == S_SQRT) begin
      unit_a = {rem_q[UW-3:0], x_q[RW-1:RW-2]};
      unit_b = {res_q[UW-3:0], 2'b01};
    end else begin
      unit_a = {rem_q[UW-2:0], x_q[RW-1]};
      unit_b = UW'(n_eff);
    end
    unit_ge   = unit_a >= unit_b;
    unit_diff = unit_a - unit_b;
  end

  // scaled value >> 32, saturated
  assign chan_byte = (|prod_q[PW-1:40]) ? {BW{1'b1}} : prod_q[39:32];

  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    step_d  = step_q;
    x_d     = x_q;
    rem_d   = rem_q;
    res_d   = res_q;
    case (state_q)
      S_IDLE: begin
        if (s_fire && finish) begin
          state_d = S_LOAD;
          ch_d    = CH_RED;
        end
      end
      S_LOAD: begin
        x_d     = {chan_sum, (RW-NW)'(0)};
        rem_d   = '0;
        res_d   = '0;
        step_d  = TW'(aasr_pkg::DIV_STEPS - 1);
        state_d = S_DIV;
      end
      S_DIV: begin
        x_d    = {x_q[RW-2:0], 1'b0};
        rem_d  = unit_ge ? unit_diff : unit_a;
        res_d  = {res_q[NW-2:0], unit_ge};
        step_d = step_q - TW'(1);
        if (last_step) begin
          if (gamma_enable_q) begin
            // radicand = quotient << 16
            x_d     = {1'b0, res_q[NW-2:0], unit_ge, 16'd0};
            rem_d   = '0;
            res_d   = '0;
            step_d  = TW'(aasr_pkg::SQRT_STEPS - 1);
            state_d = S_SQRT;
          end else begin
            state_d = S_MUL;
          end
        end
      end
      S_SQRT: begin
        x_d    = {x_q[RW-3:0], 2'b00};
        rem_d  = unit_ge ? unit_diff : unit_a;
        res_d  = {res_q[NW-2:0], unit_ge};
        step_d = step_q - TW'(1);
        if (last_step) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_STORE;
      end
      S_STORE: begin
        if (ch_q != CH_BLUE) begin
          ch_d    = ch_q + 2'd1;
          state_d = S_LOAD;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      ch_q           <= CH_RED;
      step_q         <= '0;
      spp_q          <= aasr_pkg::SPP_W'(1);
      gamma_enable_q <= 1'b0;
      red_sum_q      <= '0;
      green_sum_q    <= '0;
      blue_sum_q     <= '0;
      count_q        <= '0;
      m_valid_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      step_q  <= step_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          aasr_pkg::REG_SPP:   spp_q          <= cfg_data_i;
          aasr_pkg::REG_GAMMA: gamma_enable_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (s_fire) begin
        red_sum_q   <= red_sum_q   + NW'(s_axis_tdata_i[SW-1:0]);
        green_sum_q <= green_sum_q + NW'(s_axis_tdata_i[2*SW-1:SW]);
        blue_sum_q  <= blue_sum_q  + NW'(s_axis_tdata_i[3*SW-1:2*SW]);
        if (!finish) begin
          count_q <= count_q + aasr_pkg::COUNT_W'(1);
        end
      end
      if (store_out) begin
        red_sum_q   <= '0;
        green_sum_q <= '0;
        blue_sum_q  <= '0;
        count_q     <= '0;
        m_valid_q   <= 1'b1;
      end else if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    rem_q <= rem_d;
    res_q <= res_d;
    if (state_q == S_MUL) begin
      prod_q <= PW'(res_q) * PW'(aasr_pkg::SCALE_Q16);
    end
    if (state_q == S_STORE) begin
      if (ch_q == CH_RED) begin
        red_byte_q <= chan_byte;
      end
      if (ch_q == CH_GREEN) begin
        green_byte_q <= chan_byte;
      end
    end
    if (store_out) begin
      m_data_q <= {chan_byte, green_byte_q, red_byte_q};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  `ASSERT_PROP(a_final_sample_starts_resolve, clk_i, rst_ni,
    (s_fire && finish) |=> (state_q == S_LOAD && ch_q == CH_RED),
    "final sample did not start the resolve")
  `ASSERT_PROP(a_div_exits_cleanly, clk_i, rst_ni,
    (state_q == S_DIV) |=> (state_q == S_DIV || state_q == S_SQRT || state_q == S_MUL),
    "divide left to an unexpected state")
  `ASSERT_NEVER(a_root_only_with_gamma, clk_i, rst_ni,
    (state_q == S_SQRT) && !gamma_enable_q,
    "root pass without gamma enabled")
  `ASSERT_PROP(a_sums_clear_on_pixel, clk_i, rst_ni,
    $past(store_out) |-> (red_sum_q == '0 && green_sum_q == '0 && blue_sum_q == '0
                          && count_q == '0 && m_valid_q),
    "accumulators not cleared when pixel issued")
endmodule
`default_nettype wire
